/* rtl/xsrg_pkg.sv */
// ----------------------------------------------------------------------------
// xsrg_pkg
// Shared constants and types for the xorshift64* range generator.
// ----------------------------------------------------------------------------
package xsrg_pkg;

    localparam int DRAW_W  = 32;
    localparam int STATE_W = 64;
    localparam int DIGIT_W = 8;

    typedef logic [DRAW_W-1:0]  t_word;
    typedef logic [STATE_W-1:0] t_dword;

    localparam t_dword GOLDEN_SEED = 64'h9e37_79b9_7f4a_7c15;
    localparam t_dword STAR_MULT   = 64'd2685821657736338717;

    localparam int SHIFT_A = 12;
    localparam int SHIFT_B = 25;
    localparam int SHIFT_C = 27;

endpackage

/* rtl/xorshift64_star_range_generator_unit.sv */
// ----------------------------------------------------------------------------
// xorshift64_star_range_generator_unit
// Seeded xorshift64* generator that answers signed range requests.
//
// Channel  Direction  Handshake                Payload
// in       input      i_in_valid / o_in_stall  i_range_low, i_range_high
// out      output     o_out_valid / i_out_stall o_raw_draw, o_bounded_value
// cfg      input      APB psel/penable/pready  seed at byte address 0
//
// A result is worked out by the eight digit steps of the multiplier and the 32
// steps of the remainder divider, and the next request can transfer once the
// result has moved into the output register. A request that covers the full
// 32-bit range skips the divider. Reset is synchronous and loads the
// golden-ratio state. A waiting result is held in the output register while
// the next request is taken; the block stalls its input while a request is
// being worked on, and a finished request waits while the output register
// still holds an unaccepted result.
// ----------------------------------------------------------------------------
module xorshift64_star_range_generator_unit
    import xsrg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic        [31:0] o_raw_draw,
    output logic signed [31:0] o_bounded_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic         [3:0] paddr,
    input  logic        [63:0] pwdata,
    output logic        [63:0] prdata,
    output logic               pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_fsm;
    logic [1:0] n_fsm;
    t_dword     r_seed;
    t_dword     n_seed;
    t_dword     r_gen;
    t_dword     n_gen;
    t_word      r_lo;
    t_word      n_lo;
    t_word      r_span;
    t_word      n_span;
    t_word      r_draw;
    t_word      n_draw;
    t_word      r_bnd;
    t_word      n_bnd;
    logic       r_ovalid;
    logic       n_ovalid;
    t_word      r_odraw;
    t_word      n_odraw;
    t_word      r_obnd;
    t_word      n_obnd;

    logic       w_accept;
    logic       w_cfg_wr;
    logic       w_swap;
    t_word      w_lo;
    t_word      w_hi;
    t_dword     w_x1;
    t_dword     w_x2;
    t_dword     w_x3;
    logic       w_mul_done;
    t_dword     w_prod;
    logic       w_div_start;
    logic       w_div_done;
    t_word      w_rem;
    logic       w_out_free;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[3] == 1'b0);
    assign w_swap     = i_range_high < i_range_low;
    assign w_lo       = w_swap ? i_range_high : i_range_low;
    assign w_hi       = w_swap ? i_range_low : i_range_high;
    assign w_x1       = r_gen ^ (r_gen >> SHIFT_A);
    assign w_x2       = w_x1 ^ (w_x1 << SHIFT_B);
    assign w_x3       = w_x2 ^ (w_x2 >> SHIFT_C);
    assign w_out_free = !r_ovalid || !i_out_stall;
    assign w_div_start = (r_fsm == S_MUL) && w_mul_done && (r_span != '0);

    xsrg_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_x     (w_x3),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    xsrg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod[STATE_W-1:DRAW_W]),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_fsm    = r_fsm;
        n_seed   = r_seed;
        n_gen    = r_gen;
        n_lo     = r_lo;
        n_span   = r_span;
        n_draw   = r_draw;
        n_bnd    = r_bnd;
        n_ovalid = r_ovalid;
        n_odraw  = r_odraw;
        n_obnd   = r_obnd;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        if (w_cfg_wr) begin
            n_seed = pwdata;
            n_gen  = (pwdata == '0) ? GOLDEN_SEED : pwdata;
        end else if (w_accept) begin
            n_gen = w_x3;
        end

        case (r_fsm)
            S_IDLE: begin
                if (w_accept) begin
                    n_lo   = w_lo;
                    n_span = w_hi - w_lo + 1'b1;
                    n_fsm  = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_draw = w_prod[STATE_W-1:DRAW_W];
                    if (r_span == '0) begin
                        n_bnd = w_prod[STATE_W-1:DRAW_W];
                        n_fsm = S_DONE;
                    end else begin
                        n_fsm = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_bnd = r_lo + w_rem;
                    n_fsm = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odraw  = r_draw;
                    n_obnd   = r_bnd;
                    n_fsm    = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_seed   <= '0;
            r_gen    <= GOLDEN_SEED;
            r_ovalid <= 1'b0;
        end else begin
            r_fsm    <= n_fsm;
            r_seed   <= n_seed;
            r_gen    <= n_gen;
            r_ovalid <= n_ovalid;
        end
        r_lo    <= n_lo;
        r_span  <= n_span;
        r_draw  <= n_draw;
        r_bnd   <= n_bnd;
        r_odraw <= n_odraw;
        r_obnd  <= n_obnd;
    end

    assign o_in_stall      = (r_fsm != S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_raw_draw      = r_odraw;
    assign o_bounded_value = r_obnd;
    assign pready          = 1'b1;
    assign prdata          = (paddr[3] == 1'b0) ? r_seed : '0;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("Input not stalled after a transfer.");

    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_fsm == S_MUL))
        else $error("Multiplier finished outside the multiply phase.");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_fsm == S_DIV))
        else $error("Divider finished outside the divide phase.");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_fsm) == S_DONE))
        else $error("Result presented without a finished request.");

endmodule

/* rtl/xsrg_mult.sv */
// ----------------------------------------------------------------------------
// xsrg_mult
// Digit-serial multiplier by the scrambling constant, low 64 product bits.
// ----------------------------------------------------------------------------
module xsrg_mult
    import xsrg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_dword i_x,
    output logic   o_done,
    output t_dword o_prod
);

    localparam int DIGITS = STATE_W / DIGIT_W;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

    t_dword             r_x;
    t_dword             n_x;
    t_dword             r_k;
    t_dword             n_k;
    t_dword             r_acc;
    t_dword             n_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_busy;
    logic               n_busy;
    logic               r_done;
    logic               n_done;
    logic [STATE_W+DIGIT_W-1:0] w_prod;

    assign w_prod = {{DIGIT_W{1'b0}}, r_x} * {{STATE_W{1'b0}}, r_k[DIGIT_W-1:0]};

    always_comb begin
        n_x    = r_x;
        n_k    = r_k;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_x    = i_x;
            n_k    = STAR_MULT;
            n_acc  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = r_acc + w_prod[STATE_W-1:0];
            n_x   = r_x << DIGIT_W;
            n_k   = r_k >> DIGIT_W;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x   <= n_x;
        r_k   <= n_k;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* rtl/xsrg_div.sv */
// ----------------------------------------------------------------------------
// xsrg_div
// Bit-serial restoring divider that returns the remainder of a 32-bit draw.
// ----------------------------------------------------------------------------
module xsrg_div
    import xsrg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_dividend,
    input  t_word i_divisor,
    output logic  o_done,
    output t_word o_rem
);

    localparam int CNT_W = $clog2(DRAW_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DRAW_W - 1);

    t_word              r_q;
    t_word              n_q;
    t_word              r_rem;
    t_word              n_rem;
    t_word              r_div;
    t_word              n_div;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_busy;
    logic               n_busy;
    logic               r_done;
    logic               n_done;
    logic [DRAW_W:0]    w_trial;
    logic [DRAW_W:0]    w_diff;

    assign w_trial = {r_rem, r_q[DRAW_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q   = r_q << 1;
            n_rem = w_diff[DRAW_W] ? w_trial[DRAW_W-1:0] : w_diff[DRAW_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* bench/xorshift64_star_range_generator_unit_tb.sv */
// ----------------------------------------------------------------------------
// xorshift64_star_range_generator_unit_tb
// Self-checking bench for the seeded xorshift64* range generator. Requests are
// driven on the input channel. A predictor of the generator state works out
// the raw draw and the bounded value of each request, and every result
// transfer is compared with the oldest prediction. The seed register is
// written and read back over the APB port while the block is idle. Traffic
// runs with and without random idle cycles on the sender and random stalls
// on the receiver.
// ----------------------------------------------------------------------------
module xorshift64_star_range_generator_unit_tb;

    import xsrg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] SEED_ADDR   = 4'd0;
    localparam logic [3:0] UNUSED_ADDR = 4'd8;
    localparam t_word      INT_MIN     = 32'h8000_0000;
    localparam t_word      INT_MAX     = 32'h7fff_ffff;
    localparam int         DRAIN_WAIT  = 64;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         RANDOM_ITEMS_PER_PHASE = 400;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;

    typedef struct packed {
        t_word draw;
        t_word bounded;
    } t_draw_result;

    typedef struct packed {
        t_word low;
        t_word high;
    } t_bounds;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_range_low = '0;
    logic signed [31:0] i_range_high = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic        [31:0] o_raw_draw;
    logic signed [31:0] o_bounded_value;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic         [3:0] paddr = '0;
    logic        [63:0] pwdata = '0;
    logic        [63:0] prdata;
    logic               pready;

    t_dword       gen_state = GOLDEN_SEED;
    t_dword       seed_value = '0;
    t_draw_result pending_draws[$];
    t_draw_result oldest_draw;
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;

    xorshift64_star_range_generator_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_raw_draw     (o_raw_draw),
        .o_bounded_value(o_bounded_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input t_dword want, input t_dword got);
        $display("%0t mismatch in %s: expected %h, got %h", $realtime, what, want, got);
        error_count++;
    endtask

    function automatic t_draw_result predict_draw(input t_word low_in, input t_word high_in);
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic signed [31:0] swap;
        t_word              span;
        t_dword             product;
        t_draw_result       res;
        low = low_in;
        high = high_in;
        if (high < low) begin
            swap = low;
            low = high;
            high = swap;
        end
        span = t_word'(high) - t_word'(low) + 32'd1;
        gen_state = gen_state ^ (gen_state >> SHIFT_A);
        gen_state = gen_state ^ (gen_state << SHIFT_B);
        gen_state = gen_state ^ (gen_state >> SHIFT_C);
        product = gen_state * STAR_MULT;
        res.draw = product[63:32];
        if (span == 32'd0) begin
            res.bounded = res.draw;
        end else begin
            res.bounded = t_word'(low) + (res.draw % span);
        end
        return res;
    endfunction

    function automatic t_bounds random_bounds();
        t_bounds b;
        int      k;
        case ($urandom_range(9))
            4: begin
                b.low = $urandom;
                b.high = b.low + $urandom_range(15);
            end
            5: begin
                b.low = $urandom;
                b.high = b.low;
            end
            6: begin
                if ($urandom_range(1)) begin
                    b.low = INT_MIN;
                    b.high = INT_MAX;
                end else begin
                    b.low = INT_MAX;
                    b.high = INT_MIN;
                end
            end
            7: begin
                b.low = INT_MIN + $urandom_range(255);
                b.high = INT_MAX - $urandom_range(255);
            end
            8: begin
                k = $urandom_range(31);
                b.low = $urandom;
                b.high = b.low + ((32'd1 << k) - 32'd1);
            end
            9: begin
                b.low = $urandom_range(1000) - 500;
                b.high = $urandom_range(1000) - 500;
            end
            default: begin
                b.low = $urandom;
                b.high = $urandom;
            end
        endcase
        return b;
    endfunction

    task automatic send_request(input t_word low, input t_word high);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_range_low <= low;
        i_range_high <= high;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_draws.push_back(predict_draw(low, high));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [3:0] addr, input t_dword value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == SEED_ADDR) begin
            seed_value = value;
            gen_state = (value != '0) ? value : GOLDEN_SEED;
        end
    endtask

    task automatic check_seed_readback();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= SEED_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== seed_value) report_mismatch("seed readback", seed_value, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct = 47;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct = 47;
            end
            IDLE_BOTH: begin
                send_idle_pct = 25;
                stall_pct = 25;
            end
            default: begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    task automatic test_after_reset();
        check_seed_readback();
        send_request(32'd0, 32'd99);
        send_request(-32'sd100, 32'sd100);
        wait_drained();
    endtask

    task automatic test_bound_extremes();
        send_request(INT_MIN, INT_MAX);
        send_request(INT_MAX, INT_MIN);
        send_request(32'd0, 32'd0);
        send_request(INT_MIN, INT_MIN);
        send_request(INT_MAX, INT_MAX);
        send_request(32'sd10, -32'sd10);
        send_request(32'hffff_ffff, 32'd0);
        send_request(INT_MIN + 32'd1, INT_MAX);
        send_request(INT_MIN, INT_MAX - 32'd1);
        send_request(32'd0, INT_MAX);
        send_request(INT_MIN, 32'hffff_ffff);
        send_request(32'd0, 32'd1);
        send_request(32'h5555_5555, 32'haaaa_aaaa);
        wait_drained();
    endtask

    task automatic test_seed_register();
        t_dword seeds[5];
        seeds[0] = '0;
        seeds[1] = '1;
        seeds[2] = 64'd1;
        seeds[3] = 64'h8000_0000_0000_0000;
        seeds[4] = {$urandom, $urandom};
        foreach (seeds[i]) begin
            write_register(SEED_ADDR, seeds[i]);
            check_seed_readback();
            send_request($urandom, $urandom);
            send_request(32'd0, 32'd6);
            wait_drained();
        end
        write_register(UNUSED_ADDR, 64'h0123_4567_89ab_cdef);
        check_seed_readback();
        send_request(32'd1, 32'd1000);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        t_bounds b;
        t_dword  seed;
        for (int mode = IDLE_NONE; mode <= IDLE_BOTH; mode++) begin
            set_idling(t_idling'(mode));
            seed = ($urandom_range(4) == 0) ? t_dword'(0) : {$urandom, $urandom};
            write_register(SEED_ADDR, seed);
            check_seed_readback();
            repeat (RANDOM_ITEMS_PER_PHASE) begin
                b = random_bounds();
                send_request(b.low, b.high);
            end
            wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_draws.size() == 0) begin
                report_mismatch("unexpected result", '0, {o_raw_draw, o_bounded_value});
            end else begin
                oldest_draw = pending_draws.pop_front();
                if (o_raw_draw !== oldest_draw.draw) begin
                    report_mismatch("raw_draw", t_dword'(oldest_draw.draw),
                                    t_dword'(o_raw_draw));
                end
                if (o_bounded_value !== oldest_draw.bounded) begin
                    report_mismatch("bounded_value", t_dword'(oldest_draw.bounded),
                                    t_dword'(t_word'(o_bounded_value)));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idling(IDLE_NONE);
        test_after_reset();
        test_bound_extremes();
        test_seed_register();
        test_random_traffic();
        wait_drained();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* xorshift64_star_range_generator_unit.f */
rtl/xsrg_pkg.sv
rtl/xsrg_mult.sv
rtl/xsrg_div.sv
rtl/xorshift64_star_range_generator_unit.sv
bench/xorshift64_star_range_generator_unit_tb.sv
